/* rtl/bpskrrc_pkg.sv */
package bpskrrc_pkg;

  // Operation carried by each input item.
  typedef enum logic [1:0] {
    FUNC_TAP_WR = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Status returned with each result item.
  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_NO_PACKET = 2'd2
  } err_t;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_INDEX_W = 6;
  localparam int BYTE_W      = 8;
  localparam int FRAC_BITS   = 15;
  localparam int AMP_W       = 17;
  localparam int PROD_W      = AMP_W + SAMPLE_W;

  // Impulse heights for a one bit and a zero bit.
  localparam logic signed [AMP_W-1:0] AMP_ONE  = 17'sh07FFF;
  localparam logic signed [AMP_W-1:0] AMP_ZERO = 17'sh18000;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

endpackage

/* rtl/bpskrrc_in_if.sv */
interface bpskrrc_in_if
  import bpskrrc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  func_t                      func;
  logic [TAP_INDEX_W-1:0]     tap_index;
  logic signed [SAMPLE_W-1:0] tap_value;
  logic [BYTE_W-1:0]          data_byte;

  modport source (output valid, func, tap_index, tap_value, data_byte, input ready);
  modport sink   (input valid, func, tap_index, tap_value, data_byte, output ready);
endinterface

/* rtl/bpskrrc_out_if.sv */
interface bpskrrc_out_if
  import bpskrrc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  err_t                       error_code;
  logic                       last_sample;
  logic                       ready_for_data;
  logic                       packet_full;

  modport source (output valid, sample, error_code, last_sample, ready_for_data, packet_full,
                  input ready);
  modport sink   (input valid, sample, error_code, last_sample, ready_for_data, packet_full,
                  output ready);
endinterface

/* rtl/bpsk_rrc_packet_modulator_top.sv */
// Channel  Direction  Payload                                               Handshake
// in_ch    input      func, tap_index, tap_value, data_byte                 valid / ready
// out_ch   output     sample, error_code, last_sample, ready_for_data,      valid / ready
//                     packet_full
//
// Tap writes, byte pushes, rejected requests and unused codes finish in the accepting
// cycle; their result item is in the output register on the next cycle.
// A sample item reads one tap per contributing symbol from the single read port of the
// tap memory, then passes a multiply and an accumulate stage.
// Reset is synchronous and active low; the tap memory is not cleared and holds garbage
// until written. A stalled output holds the finished item and blocks the next one.
module bpsk_rrc_packet_modulator_top
  import bpskrrc_pkg::*;
#(
  parameter int TAPS               = 64,
  parameter int SAMPLES_PER_SYMBOL = 16,
  parameter int PAYLOAD_BYTES      = 4,
  parameter int PREAMBLE_BITS      = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  bpskrrc_in_if.sink    in_ch,
  bpskrrc_out_if.source out_ch
);

  // Packet and waveform geometry.
  localparam int TOTAL_BITS = PREAMBLE_BITS + 8 * PAYLOAD_BYTES;
  localparam int WAVE_LEN   = SAMPLES_PER_SYMBOL * TOTAL_BITS + TAPS + 1;
  localparam int IDX_W      = $clog2(WAVE_LEN);
  localparam int SYM_W      = $clog2(WAVE_LEN / SAMPLES_PER_SYMBOL + 1);
  localparam int PH_W       = $clog2(SAMPLES_PER_SYMBOL);
  localparam int KW         = $clog2(TAPS + SAMPLES_PER_SYMBOL);
  localparam int AW         = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TIDX_W     = (AW > TAP_INDEX_W) ? AW : TAP_INDEX_W;
  localparam int NCONTRIB   = (TAPS + SAMPLES_PER_SYMBOL - 1) / SAMPLES_PER_SYMBOL;
  localparam int ACC_W      = PROD_W + $clog2(NCONTRIB + 1);
  localparam int PAY_BITS   = 8 * PAYLOAD_BYTES;
  localparam int PAY_W      = $clog2(PAY_BITS);
  localparam int CNT_W      = $clog2(PAYLOAD_BYTES + 1);
  localparam int SLOT_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(32768);

  // Sequencer: RUN reads at most one tap per cycle, MUL and ADD drain the pipeline.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_MUL  = 4'b0100,
    S_ADD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Packet and waveform position. The sample index is kept split into a symbol count
  // and a phase within the symbol, so that no division is needed to find the taps.
  logic [IDX_W-1:0]    sample_idx_r, sample_idx_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [PH_W-1:0]     phase_r, phase_nxt;
  logic [CNT_W-1:0]    byte_cnt_r, byte_cnt_nxt;
  logic [PAY_BITS-1:0] payload_r, payload_nxt;

  // Convolution walk: symbol i_r contributes tap k_r; each step moves one symbol back.
  logic [SYM_W-1:0] i_r, i_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             prod_vld_r, prod_vld_nxt;
  logic             bit_r, bit_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // Status for the sample item in flight.
  logic pend_last_r, pend_last_nxt;
  logic pend_rfd_r, pend_rfd_nxt;
  logic pend_full_r, pend_full_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  err_t                       out_err_r, out_err_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_rfd_r, out_rfd_nxt;
  logic                       out_full_r, out_full_nxt;

  logic                       in_ready;
  logic                       accept;
  logic                       out_free;
  logic                       pkt_full;
  logic [TIDX_W-1:0]          tap_idx_ext;
  logic                       tap_we;
  logic [SAMPLE_W-1:0]        tap_rdata;
  logic                       issue;
  logic [KW:0]                k_sum;
  logic                       step_last;
  logic [SYM_W-1:0]           pay_off;
  logic                       pre_bit;
  logic                       cur_bit;
  logic signed [ACC_W-1:0]    prod_add;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] sat_sample;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ready;
  assign pkt_full = (byte_cnt_r == CNT_W'(PAYLOAD_BYTES));

  // Tap writes beyond the filter length are ignored.
  assign tap_idx_ext = TIDX_W'(in_ch.tap_index);
  assign tap_we      = accept && (in_ch.func == FUNC_TAP_WR) && (32'(in_ch.tap_index) < TAPS);

  bpskrrc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_tap_ram (
    .clk     (clk),
    .wr_en   (tap_we),
    .wr_addr (tap_idx_ext[AW-1:0]),
    .wr_data (in_ch.tap_value),
    .rd_en   (issue),
    .rd_addr (k_r[AW-1:0]),
    .rd_data (tap_rdata)
  );

  // A step reads a tap only if it lies inside the filter and the symbol exists.
  assign issue     = (state_r == S_RUN) && (k_r < KW'(TAPS)) && (i_r < SYM_W'(TOTAL_BITS));
  assign k_sum     = (KW + 1)'(k_r) + (KW + 1)'(SAMPLES_PER_SYMBOL);
  assign step_last = (i_r == '0) || (k_sum >= (KW + 1)'(TAPS));

  // The preamble alternates starting with a one; its final bit repeats the one before.
  assign pre_bit = (i_r == SYM_W'(PREAMBLE_BITS - 1)) ? i_r[0] : ~i_r[0];
  assign pay_off = i_r - SYM_W'(PREAMBLE_BITS);
  assign cur_bit = (i_r < SYM_W'(PREAMBLE_BITS)) ? pre_bit : payload_r[pay_off[PAY_W-1:0]];

  // Accumulate, then floor-shift and saturate to q15.
  assign prod_add = prod_vld_r ? ACC_W'(prod_r) : ACC_W'(0);
  assign acc_sum  = acc_r + prod_add;
  assign acc_q    = acc_sum >>> FRAC_BITS;

  always_comb begin
    if (acc_q > ACC_MAX) begin
      sat_sample = Q15_MAX;
    end else if (acc_q < ACC_MIN) begin
      sat_sample = Q15_MIN;
    end else begin
      sat_sample = SAMPLE_W'(acc_q);
    end
  end

  always_comb begin
    logic res_last;
    err_t res_err;
    logic run;

    state_nxt      = state_r;
    sample_idx_nxt = sample_idx_r;
    sym_nxt        = sym_r;
    phase_nxt      = phase_r;
    byte_cnt_nxt   = byte_cnt_r;
    payload_nxt    = payload_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    rd_vld_nxt     = issue;
    prod_vld_nxt   = rd_vld_r;
    bit_nxt        = cur_bit;
    prod_nxt       = PROD_W'(bit_r ? AMP_ONE : AMP_ZERO) * PROD_W'($signed(tap_rdata));
    acc_nxt        = acc_r;
    pend_last_nxt  = pend_last_r;
    pend_rfd_nxt   = pend_rfd_r;
    pend_full_nxt  = pend_full_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sample_nxt = out_sample_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    out_rfd_nxt    = out_rfd_r;
    out_full_nxt   = out_full_r;
    res_last       = 1'b0;
    res_err        = ERR_OK;
    run            = 1'b0;

    if (accept) begin
      unique case (in_ch.func)
        FUNC_TAP_WR: begin
        end
        FUNC_BYTE: begin
          if (pkt_full) begin
            res_err = ERR_FULL;
          end else begin
            payload_nxt[{byte_cnt_r[SLOT_W-1:0], 3'b000} +: BYTE_W] = in_ch.data_byte;
            byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
          end
        end
        FUNC_SAMPLE: begin
          if (!pkt_full) begin
            res_err = ERR_NO_PACKET;
          end else begin
            run   = 1'b1;
            i_nxt = sym_r;
            k_nxt = KW'(phase_r);
            if (sample_idx_r == IDX_W'(WAVE_LEN - 1)) begin
              // End of waveform: rewind and drop back to the bare preamble.
              sample_idx_nxt = '0;
              sym_nxt        = '0;
              phase_nxt      = '0;
              byte_cnt_nxt   = '0;
              res_last       = 1'b1;
            end else begin
              sample_idx_nxt = sample_idx_r + IDX_W'(1);
              if (phase_r == PH_W'(SAMPLES_PER_SYMBOL - 1)) begin
                phase_nxt = '0;
                sym_nxt   = sym_r + SYM_W'(1);
              end else begin
                phase_nxt = phase_r + PH_W'(1);
              end
            end
          end
        end
        FUNC_NONE: begin
        end
        default: begin
        end
      endcase

      if (run) begin
        state_nxt     = S_RUN;
        acc_nxt       = '0;
        rd_vld_nxt    = 1'b0;
        prod_vld_nxt  = 1'b0;
        pend_last_nxt = res_last;
        pend_rfd_nxt  = (sample_idx_nxt == '0);
        pend_full_nxt = (byte_cnt_nxt == CNT_W'(PAYLOAD_BYTES));
      end else begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = '0;
        out_err_nxt    = res_err;
        out_last_nxt   = 1'b0;
        out_rfd_nxt    = (sample_idx_r == '0);
        out_full_nxt   = (byte_cnt_nxt == CNT_W'(PAYLOAD_BYTES));
      end
    end else begin
      if (state_r != S_IDLE) begin
        acc_nxt = acc_sum;
      end
      unique case (state_r)
        S_IDLE: begin
        end
        S_RUN: begin
          k_nxt = k_sum[KW-1:0];
          i_nxt = i_r - SYM_W'(1);
          if (step_last) begin
            state_nxt = S_MUL;
          end
        end
        S_MUL: begin
          state_nxt = S_ADD;
        end
        S_ADD: begin
          // The last product lands here; wait while the output register is occupied.
          if (out_free) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_sample_nxt = sat_sample;
            out_err_nxt    = ERR_OK;
            out_last_nxt   = pend_last_r;
            out_rfd_nxt    = pend_rfd_r;
            out_full_nxt   = pend_full_r;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sample_idx_r <= '0;
      sym_r        <= '0;
      phase_r      <= '0;
      byte_cnt_r   <= '0;
      payload_r    <= '0;
      rd_vld_r     <= 1'b0;
      prod_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sample_idx_r <= sample_idx_nxt;
      sym_r        <= sym_nxt;
      phase_r      <= phase_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      payload_r    <= payload_nxt;
      rd_vld_r     <= rd_vld_nxt;
      prod_vld_r   <= prod_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    bit_r        <= bit_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_rfd_r   <= pend_rfd_nxt;
    pend_full_r  <= pend_full_nxt;
    out_sample_r <= out_sample_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
    out_rfd_r    <= out_rfd_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample         = out_sample_r;
  assign out_ch.error_code     = out_err_r;
  assign out_ch.last_sample    = out_last_r;
  assign out_ch.ready_for_data = out_rfd_r;
  assign out_ch.packet_full    = out_full_r;

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE))
    else $error("input accepted while a sample is in progress");

  a_byte_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_W'(PAYLOAD_BYTES))
    else $error("payload byte count beyond packet size");

  a_wave_needs_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_idx_r != '0) |-> pkt_full)
    else $error("waveform in progress without a full packet");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_W'(SAMPLES_PER_SYMBOL - 1))
    else $error("symbol phase out of range");

  a_sample_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("finished sample did not reach the output register");
`endif

endmodule

/* rtl/bpskrrc_ram.sv */
module bpskrrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* verif/bpsk_rrc_packet_modulator_top_tb.sv */
`timescale 1ns / 1ps

module bpsk_rrc_packet_modulator_top_tb;
  import bpskrrc_pkg::*;

  // Geometry of the block under test. These match the default parameters of the top level.
  localparam int TAPS               = 64;
  localparam int SAMPLES_PER_SYMBOL = 16;
  localparam int PAYLOAD_BYTES      = 4;
  localparam int PREAMBLE_BITS      = 8;
  localparam int TOTAL_BITS         = PREAMBLE_BITS + 8 * PAYLOAD_BYTES;
  localparam int CONV_LEN           = SAMPLES_PER_SYMBOL * TOTAL_BITS + TAPS - 1;
  localparam int WAVE_LEN           = SAMPLES_PER_SYMBOL * TOTAL_BITS + TAPS + 1;

  // Quiet period at the end of the run, after every result item has come back.
  localparam int SETTLE_CYCLES = 20;

  // Number of random items sent after the tap load and the directed part.
  localparam int RANDOM_ITEMS = 363;

  // One result item as the block should present it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    err_t                       error_code;
    logic                       last_sample;
    logic                       ready_for_data;
    logic                       packet_full;
  } wave_result_t;

  // The scoreboard keeps its own copy of the taps, the packet and the waveform position.
  // Every accepted input item advances that copy and queues the result it should cause.
  class wave_scoreboard;
    logic signed [SAMPLE_W-1:0] taps[TAPS];
    logic [8*PAYLOAD_BYTES-1:0] payload;
    int                         bits_loaded;
    int                         wave_pos;
    int                         mismatches;
    wave_result_t               awaited_results[$];

    function new();
      foreach (taps[k]) taps[k] = '0;
      payload     = '0;
      bits_loaded = PREAMBLE_BITS;
      wave_pos    = 0;
      mismatches  = 0;
    endfunction

    function bit packet_ready();
      return bits_loaded == TOTAL_BITS;
    endfunction

    // The preamble alternates 1,0,1,... and its final bit is inverted to mark the frame start.
    function bit symbol_bit(int i);
      if (i < PREAMBLE_BITS - 1) return (i % 2) == 0;
      if (i == PREAMBLE_BITS - 1) return (i % 2) != 0;
      return payload[i - PREAMBLE_BITS];
    endfunction

    // Convolution of the impulse train with the taps, floored by 2^15 and clamped to q15.
    function logic signed [SAMPLE_W-1:0] shaped_level(int n);
      longint acc;
      longint amp;
      longint q;
      int     pos;
      acc = 0;
      for (int i = 0; i < TOTAL_BITS; i++) begin
        pos = SAMPLES_PER_SYMBOL * i;
        if (n >= pos && n - pos < TAPS) begin
          amp = symbol_bit(i) ? 64'sd32767 : -64'sd32768;
          acc += amp * longint'(taps[n - pos]);
        end
      end
      q = acc >>> FRAC_BITS;
      if (q > longint'(Q15_MAX)) q = longint'(Q15_MAX);
      if (q < longint'(Q15_MIN)) q = longint'(Q15_MIN);
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_input(func_t f, logic [TAP_INDEX_W-1:0] idx,
                             logic signed [SAMPLE_W-1:0] val, logic [BYTE_W-1:0] data);
      wave_result_t r;
      r.sample      = '0;
      r.error_code  = ERR_OK;
      r.last_sample = 1'b0;
      case (f)
        FUNC_TAP_WR: begin
          if (idx < TAPS) taps[idx] = val;
        end
        FUNC_BYTE: begin
          if (bits_loaded >= TOTAL_BITS) begin
            r.error_code = ERR_FULL;
          end else begin
            payload[bits_loaded - PREAMBLE_BITS +: 8] = data;
            bits_loaded += 8;
          end
        end
        FUNC_SAMPLE: begin
          if (bits_loaded != TOTAL_BITS) begin
            r.error_code = ERR_NO_PACKET;
          end else begin
            if (wave_pos < CONV_LEN) r.sample = shaped_level(wave_pos);
            wave_pos++;
            if (wave_pos >= WAVE_LEN) begin
              wave_pos      = 0;
              bits_loaded   = PREAMBLE_BITS;
              r.last_sample = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      r.ready_for_data = (wave_pos == 0);
      r.packet_full    = (bits_loaded == TOTAL_BITS);
      awaited_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] sample, err_t error_code,
                      logic last_sample, logic ready_for_data, logic packet_full);
      wave_result_t e;
      if (awaited_results.size() == 0) begin
        report("result item arrived with nothing outstanding");
        return;
      end
      e = awaited_results.pop_front();
      if (sample !== e.sample)
        report($sformatf("sample %0d, wanted %0d", sample, e.sample));
      if (error_code !== e.error_code)
        report($sformatf("error_code %0d, wanted %0d", error_code, e.error_code));
      if (last_sample !== e.last_sample)
        report($sformatf("last_sample %b, wanted %b", last_sample, e.last_sample));
      if (ready_for_data !== e.ready_for_data)
        report($sformatf("ready_for_data %b, wanted %b", ready_for_data, e.ready_for_data));
      if (packet_full !== e.packet_full)
        report($sformatf("packet_full %b, wanted %b", packet_full, e.packet_full));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   results_seen = 0;

  wave_scoreboard sb;

  bpskrrc_in_if  in_ch();
  bpskrrc_out_if out_ch();

  bpsk_rrc_packet_modulator_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs. A correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side. Every accepted result item goes to the scoreboard. The ready line is
  // dropped at random about 30 percent of the time, except for a long stretch in the
  // middle of the run where it stays high so that the block runs at its own pace.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.sample, out_ch.error_code, out_ch.last_sample,
                      out_ch.ready_for_data, out_ch.packet_full);
      results_seen++;
    end
    if (results_seen >= 200 && results_seen < 400) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 30);
    end
  end

  // Presents one input item and holds it until the block takes it. The item is handed to
  // the scoreboard at the edge where it is accepted, so that the next random choice
  // already sees the updated packet state. With may_idle set, the sender sometimes
  // drops valid for a gap first.
  task automatic send_item(input func_t f, input logic [TAP_INDEX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] val,
                           input logic [BYTE_W-1:0] data, input bit may_idle);
    if (may_idle && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.tap_index <= idx;
    in_ch.tap_value <= val;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(f, idx, val, data);
  endtask

  // Stops sending until every outstanding result item has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  // One random item. Once a packet is loaded, most items are sample requests so that
  // the waveform keeps going out; the rest are live tap updates, dropped bytes and unused
  // codes. While the packet is filling, most items are bytes, with early sample
  // requests, tap writes and unused codes mixed in.
  task automatic send_random(input bit may_idle);
    int                         r;
    func_t                      f;
    logic [TAP_INDEX_W-1:0]     idx;
    logic signed [SAMPLE_W-1:0] val;
    logic [BYTE_W-1:0]          data;
    r    = $urandom_range(99);
    idx  = TAP_INDEX_W'($urandom_range(TAPS - 1));
    val  = SAMPLE_W'($urandom_range(16'hFFFF));
    data = BYTE_W'($urandom_range(8'hFF));
    if (sb.packet_ready()) begin
      if (r < 85)      f = FUNC_SAMPLE;
      else if (r < 91) f = FUNC_TAP_WR;
      else if (r < 96) f = FUNC_BYTE;
      else             f = FUNC_NONE;
    end else begin
      if (r < 60)      f = FUNC_BYTE;
      else if (r < 70) f = FUNC_SAMPLE;
      else if (r < 88) f = FUNC_TAP_WR;
      else             f = FUNC_NONE;
    end
    send_item(f, idx, val, data, may_idle);
  endtask

  initial begin
    int n;
    sb              = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_NONE;
    in_ch.tap_index <= '0;
    in_ch.tap_value <= '0;
    in_ch.data_byte <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The tap memory comes out of reset undefined, so every tap is loaded before any
    // sample can read it. Full-scale taps let runs of equal bits drive the output into
    // saturation at both ends of the q15 range.
    for (int k = 0; k < TAPS; k++) begin
      send_item(FUNC_TAP_WR, TAP_INDEX_W'(k), Q15_MAX, '0, 1'b0);
    end

    // Directed part. An unused code with every field set to all ones comes first, then
    // a sample request before any packet exists.
    send_item(FUNC_NONE, '1, '1, '1, 1'b1);
    send_item(FUNC_SAMPLE, '0, '0, '0, 1'b1);
    // Extreme tap indexes and values.
    send_item(FUNC_TAP_WR, TAP_INDEX_W'(TAPS - 1), Q15_MIN, '0, 1'b1);
    send_item(FUNC_TAP_WR, '0, Q15_MAX, '0, 1'b1);
    send_item(FUNC_TAP_WR, TAP_INDEX_W'(1), '0, '0, 1'b1);
    // Long runs of ones and zeros in the payload. A sample request on a partly filled
    // packet is rejected without touching it.
    send_item(FUNC_BYTE, '0, '0, 8'hFF, 1'b1);
    send_item(FUNC_BYTE, '0, '0, 8'h00, 1'b1);
    send_item(FUNC_BYTE, '0, '0, 8'hFF, 1'b1);
    send_item(FUNC_SAMPLE, '0, '0, '0, 1'b1);
    send_item(FUNC_BYTE, '0, '0, 8'h00, 1'b1);
    // A byte offered to a full packet is dropped.
    send_item(FUNC_BYTE, '0, '0, 8'hA5, 1'b1);
    // The waveform starts. A tap written now is used by the samples that follow, and a
    // byte pushed while the waveform is going out is dropped as well.
    for (int k = 0; k < 8; k++) begin
      send_item(FUNC_SAMPLE, '0, '0, '0, 1'b1);
    end
    send_item(FUNC_TAP_WR, TAP_INDEX_W'(9), 16'sh1234, '0, 1'b1);
    send_item(FUNC_SAMPLE, '0, '0, '0, 1'b1);
    send_item(FUNC_BYTE, '0, '0, 8'h5A, 1'b1);
    send_item(FUNC_NONE, '0, '0, '0, 1'b1);

    // The sender holds off here until the block has answered everything.
    wait_drained();

    // Random part. A long stretch of items is sent back to back with no gaps.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_random(!(n >= 120 && n < 300));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
